### sv/irfp_pkg.sv
`default_nettype none

package irfp_pkg;

    localparam int PALETTE_NUM   = 8;
    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_ENTRIES   = PALETTE_NUM * PALETTE_DEPTH;
    localparam int PAL_AW        = $clog2(PAL_ENTRIES);
    localparam int REG_COUNT     = 256;

    // Command codes.
    localparam logic [2:0] CMD_SELECT    = 3'd0;
    localparam logic [2:0] CMD_WRITE_SEL = 3'd1;
    localparam logic [2:0] CMD_WRITE_DIR = 3'd2;
    localparam logic [2:0] CMD_READ      = 3'd3;
    localparam logic [2:0] CMD_LOOKUP    = 3'd4;

    // Register numbers with side effects or reset values.
    localparam logic [7:0] REG_MACHINE_ID = 8'h00;
    localparam logic [7:0] REG_VERSION    = 8'h01;
    localparam logic [7:0] REG_SUBMINOR   = 8'h0E;
    localparam logic [7:0] REG_SPEED      = 8'h07;
    localparam logic [7:0] REG_PAL_INDEX  = 8'h40;
    localparam logic [7:0] REG_PAL_DATA8  = 8'h41;
    localparam logic [7:0] REG_PAL_SELECT = 8'h43;
    localparam logic [7:0] REG_PAL_DATA9  = 8'h44;
    localparam logic [7:0] REG_SLOT_FIRST = 8'h50;
    localparam logic [7:0] REG_SLOT_LAST  = 8'h57;

    localparam logic [7:0] MACHINE_ID_VAL = 8'h08;
    localparam logic [7:0] VERSION_VAL    = 8'h32;
    localparam logic [7:0] SUBMINOR_VAL   = 8'h01;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] reg_req;
        logic [7:0] value;
        logic [2:0] lookup_palette;
        logic [7:0] lookup_index;
    } req_beat_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [9:0] palette_entry;
        logic       slot_write;
        logic [2:0] slot_number;
        logic [7:0] slot_page;
        logic       speed_change;
        logic [1:0] speed_mult;
    } rsp_beat_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WAIT
    } state_t;

    typedef enum logic [1:0] {
        PEND_READ,
        PEND_LOOKUP,
        PEND_PAL_MOD
    } pend_t;

    function automatic logic [7:0] reg_reset_value(input logic [7:0] addr);
        logic [7:0] val;
        val = 8'h00;
        case (addr)
            REG_MACHINE_ID: val = MACHINE_ID_VAL;
            REG_VERSION:    val = VERSION_VAL;
            REG_SUBMINOR:   val = SUBMINOR_VAL;
            default:        val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

### sv/irfp_ram.sv
`default_nettype none

module irfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### sv/indexed_register_file_palette_top.sv
// Channel | Direction | Handshake              | Payload
// req     | in        | req_valid / req_stall  | irfp_pkg::req_beat_t
// rsp     | out       | rsp_valid / rsp_stall  | irfp_pkg::rsp_beat_t
//
// Select, write and unused commands are answered straight from the idle state;
// reads, palette lookups and writes to the 9-bit palette data register pass
// through the wait state for the registered read of the register and palette memories.
// After reset all 2048 palette entries are swept to zero, one entry a cycle;
// req_stall stays high until the sweep is done.
// A result waits in the output register while rsp_stall is high; a new beat is
// taken while the block is idle and that register will be free at the same edge.
`default_nettype none

module indexed_register_file_palette_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire irfp_pkg::req_beat_t req,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output irfp_pkg::rsp_beat_t      rsp
);

    import irfp_pkg::*;

    state_t              state_reg, state_next;
    pend_t               pend_reg, pend_next;
    logic [PAL_AW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [7:0]          sel_reg, sel_next;
    logic [2:0]          pal_sel_reg, pal_sel_next;
    logic [7:0]          pointer_reg, pointer_next;
    logic [1:0]          speed_reg, speed_next;
    logic [REG_COUNT-1:0] reg_valid_reg, reg_valid_next;
    logic [7:0]          hold_reg_addr_reg, hold_reg_addr_next;
    logic [PAL_AW-1:0]   hold_pal_addr_reg, hold_pal_addr_next;
    logic [7:0]          hold_value_reg, hold_value_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_beat_t           rsp_reg, rsp_next;

    logic                accept;
    logic                load_rsp;
    rsp_beat_t           beat;
    logic [7:0]          wr_reg;

    logic                reg_we;
    logic [7:0]          reg_waddr;
    logic [7:0]          reg_wdata;
    logic [7:0]          reg_raddr;
    logic [7:0]          reg_rdata;

    logic                pal_we;
    logic [PAL_AW-1:0]   pal_waddr;
    logic [9:0]          pal_wdata;
    logic [PAL_AW-1:0]   pal_raddr;
    logic [9:0]          pal_rdata;

    irfp_ram #(
        .WIDTH (8),
        .DEPTH (REG_COUNT)
    ) u_reg_ram (
        .clk   (clk),
        .we    (reg_we),
        .waddr (reg_waddr),
        .wdata (reg_wdata),
        .raddr (reg_raddr),
        .rdata (reg_rdata)
    );

    irfp_ram #(
        .WIDTH (10),
        .DEPTH (PAL_ENTRIES)
    ) u_pal_ram (
        .clk   (clk),
        .we    (pal_we),
        .waddr (pal_waddr),
        .wdata (pal_wdata),
        .raddr (pal_raddr),
        .rdata (pal_rdata)
    );

    assign req_stall = (state_reg != ST_IDLE) || (rsp_valid_reg && rsp_stall);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign wr_reg    = (req.cmd == CMD_WRITE_SEL) ? sel_reg : req.reg_req;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            pend_reg      <= PEND_READ;
            clr_cnt_reg   <= '0;
            sel_reg       <= '0;
            pal_sel_reg   <= '0;
            pointer_reg   <= '0;
            speed_reg     <= '0;
            reg_valid_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            clr_cnt_reg   <= clr_cnt_next;
            sel_reg       <= sel_next;
            pal_sel_reg   <= pal_sel_next;
            pointer_reg   <= pointer_next;
            speed_reg     <= speed_next;
            reg_valid_reg <= reg_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg_addr_reg <= hold_reg_addr_next;
        hold_pal_addr_reg <= hold_pal_addr_next;
        hold_value_reg    <= hold_value_next;
        rsp_reg           <= rsp_next;
    end

    always_comb
    begin
        state_next         = state_reg;
        pend_next          = pend_reg;
        clr_cnt_next       = clr_cnt_reg;
        sel_next           = sel_reg;
        pal_sel_next       = pal_sel_reg;
        pointer_next       = pointer_reg;
        speed_next         = speed_reg;
        reg_valid_next     = reg_valid_reg;
        hold_reg_addr_next = hold_reg_addr_reg;
        hold_pal_addr_next = hold_pal_addr_reg;
        hold_value_next    = hold_value_reg;
        rsp_valid_next     = rsp_valid_reg && rsp_stall;
        rsp_next           = rsp_reg;

        load_rsp  = 1'b0;
        beat      = '0;

        reg_we    = 1'b0;
        reg_waddr = wr_reg;
        reg_wdata = req.value;
        reg_raddr = req.reg_req;

        pal_we    = 1'b0;
        pal_waddr = {pal_sel_reg, pointer_reg};
        pal_wdata = {1'b0, req.value, 1'b0};
        pal_raddr = {req.lookup_palette, req.lookup_index};

        case (state_reg)
            ST_CLEAR:
            begin
                pal_we       = 1'b1;
                pal_waddr    = clr_cnt_reg;
                pal_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == PAL_AW'(PAL_ENTRIES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.cmd)
                        CMD_SELECT:
                        begin
                            sel_next = req.reg_req;
                            load_rsp = 1'b1;
                        end

                        CMD_WRITE_SEL, CMD_WRITE_DIR:
                        begin
                            reg_we                 = 1'b1;
                            reg_valid_next[wr_reg] = 1'b1;
                            load_rsp               = 1'b1;
                            if (wr_reg inside {[REG_SLOT_FIRST:REG_SLOT_LAST]})
                            begin
                                beat.slot_write  = 1'b1;
                                beat.slot_number = 3'(wr_reg - REG_SLOT_FIRST);
                                beat.slot_page   = req.value;
                            end
                            else
                            begin
                                case (wr_reg)
                                    REG_SPEED:
                                    begin
                                        if (req.value[1:0] != speed_reg)
                                        begin
                                            speed_next        = req.value[1:0];
                                            beat.speed_change = 1'b1;
                                        end
                                    end
                                    REG_PAL_INDEX:
                                    begin
                                        pointer_next = req.value;
                                    end
                                    REG_PAL_DATA8:
                                    begin
                                        // RGB332 widens with blue LSB and priority clear.
                                        pal_we       = 1'b1;
                                        pointer_next = pointer_reg + 1'b1;
                                    end
                                    REG_PAL_SELECT:
                                    begin
                                        pal_sel_next = {req.value[6], req.value[5:4]};
                                    end
                                    REG_PAL_DATA9:
                                    begin
                                        // Read the entry now, merge and write it back next cycle.
                                        pal_raddr          = {pal_sel_reg, pointer_reg};
                                        hold_pal_addr_next = {pal_sel_reg, pointer_reg};
                                        hold_value_next    = req.value;
                                        pointer_next       = pointer_reg + 1'b1;
                                        pend_next          = PEND_PAL_MOD;
                                        state_next         = ST_WAIT;
                                        load_rsp           = 1'b0;
                                    end
                                    default:
                                    begin
                                    end
                                endcase
                            end
                        end

                        CMD_READ:
                        begin
                            hold_reg_addr_next = req.reg_req;
                            pend_next          = PEND_READ;
                            state_next         = ST_WAIT;
                        end

                        CMD_LOOKUP:
                        begin
                            pend_next  = PEND_LOOKUP;
                            state_next = ST_WAIT;
                        end

                        default:
                        begin
                            load_rsp = 1'b1;
                        end
                    endcase
                end
            end

            ST_WAIT:
            begin
                load_rsp   = 1'b1;
                state_next = ST_IDLE;
                case (pend_reg)
                    PEND_READ:
                    begin
                        // A register never written still holds its reset value.
                        beat.read_data = reg_valid_reg[hold_reg_addr_reg] ?
                                         reg_rdata : reg_reset_value(hold_reg_addr_reg);
                    end
                    PEND_LOOKUP:
                    begin
                        beat.palette_entry = pal_rdata;
                    end
                    PEND_PAL_MOD:
                    begin
                        pal_we    = 1'b1;
                        pal_waddr = hold_pal_addr_reg;
                        pal_wdata = {hold_value_reg[7], pal_rdata[8:1], hold_value_reg[0]};
                    end
                    default:
                    begin
                    end
                endcase
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_rsp)
        begin
            beat.speed_mult = speed_next;
            rsp_next        = beat;
            rsp_valid_next  = 1'b1;
        end
    end

    property p_no_accept_in_clear;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> req_stall;
    endproperty
    a_no_accept_in_clear: assert property (p_no_accept_in_clear)
        else $error("beat accepted during palette clear");

    property p_read_goes_wait;
        @(posedge clk) disable iff (!rst_n)
        (accept && (req.cmd == CMD_READ || req.cmd == CMD_LOOKUP))
            |=> (state_reg == ST_WAIT);
    endproperty
    a_read_goes_wait: assert property (p_read_goes_wait)
        else $error("read or lookup did not wait for memory data");

    property p_wait_output_free;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAIT) |-> !rsp_valid_reg;
    endproperty
    a_wait_output_free: assert property (p_wait_output_free)
        else $error("output register occupied while a memory result is pending");

    property p_wait_one_cycle;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAIT) |=> (state_reg == ST_IDLE) && rsp_valid_reg;
    endproperty
    a_wait_one_cycle: assert property (p_wait_one_cycle)
        else $error("pending result not delivered after one cycle");

endmodule

`default_nettype wire

### dv/tb_indexed_register_file_palette_top.sv
module tb_indexed_register_file_palette_top;

    import irfp_pkg::*;

    // Command codes that the block decodes as no operation.
    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_beat_t req = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_beat_t rsp;

    // Mirror of the block's architectural state.
    logic [7:0] regs [REG_COUNT];
    logic [9:0] pal_ram [PAL_ENTRIES];
    logic [7:0] sel_reg;
    logic [2:0] pal_sel;
    logic [7:0] pal_ptr;
    logic [1:0] speed;

    rsp_beat_t rsp_due [$];
    int        fail_count = 0;
    int        beats_sent = 0;
    int        src_idle_pct = 0;
    int        rcv_idle_pct = 0;
    int        hold_len = 0;
    int        hold_count = 0;

    indexed_register_file_palette_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic clear_state();
        for (int i = 0; i < REG_COUNT; i++)
        begin
            regs[i] = 8'h00;
        end
        regs[REG_MACHINE_ID] = MACHINE_ID_VAL;
        regs[REG_VERSION]    = VERSION_VAL;
        regs[REG_SUBMINOR]   = SUBMINOR_VAL;
        for (int i = 0; i < PAL_ENTRIES; i++)
        begin
            pal_ram[i] = 10'h000;
        end
        sel_reg = 8'h00;
        pal_sel = 3'd0;
        pal_ptr = 8'h00;
        speed   = 2'd0;
    endtask

    function automatic void store_byte(input logic [7:0] a, input logic [7:0] v,
                                       inout rsp_beat_t r);
        logic [10:0] addr;
        addr = {pal_sel, pal_ptr};
        regs[a] = v;
        if (a >= REG_SLOT_FIRST && a <= REG_SLOT_LAST)
        begin
            r.slot_write  = 1'b1;
            r.slot_number = 3'(a - REG_SLOT_FIRST);
            r.slot_page   = v;
        end
        else
        begin
            case (a)
                REG_SPEED:
                begin
                    if (v[1:0] != speed)
                    begin
                        speed          = v[1:0];
                        r.speed_change = 1'b1;
                    end
                end
                REG_PAL_INDEX:  pal_ptr = v;
                REG_PAL_SELECT: pal_sel = {v[6], v[5:4]};
                REG_PAL_DATA8:
                begin
                    // RGB332 widens to RGB333 with a zero blue LSB and no priority.
                    pal_ram[addr] = {1'b0, v, 1'b0};
                    pal_ptr       = pal_ptr + 8'd1;
                end
                REG_PAL_DATA9:
                begin
                    pal_ram[addr][0] = v[0];
                    pal_ram[addr][9] = v[7];
                    pal_ptr          = pal_ptr + 8'd1;
                end
                default: ;
            endcase
        end
    endfunction

    function automatic rsp_beat_t bus_cycle(input req_beat_t b);
        rsp_beat_t r;
        r = '0;
        case (b.cmd)
            CMD_SELECT:    sel_reg = b.reg_req;
            CMD_WRITE_SEL: store_byte(sel_reg, b.value, r);
            CMD_WRITE_DIR: store_byte(b.reg_req, b.value, r);
            CMD_READ:      r.read_data = regs[b.reg_req];
            CMD_LOOKUP:    r.palette_entry = pal_ram[{b.lookup_palette, b.lookup_index}];
            default: ;
        endcase
        r.speed_mult = speed;
        return r;
    endfunction

    function automatic req_beat_t beat(input logic [2:0] c, input logic [7:0] r,
                                       input logic [7:0] v, input logic [2:0] lp,
                                       input logic [7:0] li);
        req_beat_t b;
        b.cmd            = c;
        b.reg_req        = r;
        b.value          = v;
        b.lookup_palette = lp;
        b.lookup_index   = li;
        return b;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(input req_beat_t b);
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= b;
        do
            @(posedge clk);
        while (req_stall);
        rsp_due.push_back(bus_cycle(b));
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [7:0] r, input logic [7:0] v);
        if ($urandom_range(0, 2) == 0)
        begin
            send_beat(beat(CMD_SELECT, r, 8'($urandom), 3'($urandom), 8'($urandom)));
            send_beat(beat(CMD_WRITE_SEL, 8'($urandom), v, 3'($urandom), 8'($urandom)));
        end
        else
        begin
            send_beat(beat(CMD_WRITE_DIR, r, v, 3'($urandom), 8'($urandom)));
        end
    endtask

    function automatic logic [7:0] pick_reg();
        case ($urandom_range(0, 9))
            0:       return REG_SPEED;
            1:       return REG_PAL_INDEX;
            2:       return REG_PAL_DATA8;
            3:       return REG_PAL_SELECT;
            4:       return REG_PAL_DATA9;
            5:       return REG_SLOT_FIRST + 8'($urandom_range(0, 7));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic req_beat_t random_beat();
        req_beat_t b;
        b = beat(CMD_SELECT, pick_reg(), 8'($urandom), 3'($urandom), 8'($urandom));
        case ($urandom_range(0, 19))
            0, 1, 2:        b.cmd = CMD_SELECT;
            3, 4, 5, 6:     b.cmd = CMD_WRITE_SEL;
            7, 8, 9, 10:    b.cmd = CMD_WRITE_DIR;
            11, 12, 13:     b.cmd = CMD_READ;
            14, 15, 16, 17: b.cmd = CMD_LOOKUP;
            default:        b.cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        endcase
        return b;
    endfunction

    // Program a run of entries in one palette, then read them back.
    task automatic palette_burst();
        logic [2:0] pal;
        logic [7:0] base;
        int         len;
        pal  = 3'($urandom);
        base = 8'($urandom);
        len  = $urandom_range(1, 6);
        write_reg(REG_PAL_SELECT, {1'($urandom), pal[2], pal[1:0], 4'($urandom)});
        write_reg(REG_PAL_INDEX, base);
        for (int i = 0; i < len; i++)
        begin
            write_reg($urandom_range(0, 1) ? REG_PAL_DATA8 : REG_PAL_DATA9, 8'($urandom));
        end
        for (int i = 0; i < len; i++)
        begin
            send_beat(beat(CMD_LOOKUP, 8'($urandom), 8'($urandom), pal, base + 8'(i)));
        end
    endtask

    task automatic test_reset_values();
        send_beat(beat(CMD_READ, REG_MACHINE_ID, 8'h00, 3'd0, 8'h00));
        send_beat(beat(CMD_READ, REG_VERSION, 8'h00, 3'd0, 8'h00));
        send_beat(beat(CMD_READ, REG_SUBMINOR, 8'h00, 3'd0, 8'h00));
        send_beat(beat(CMD_LOOKUP, 8'h00, 8'h00, 3'd7, 8'hFF));
        send_beat(beat(CMD_LOOKUP, 8'h00, 8'h00, 3'd0, 8'h00));
    endtask

    task automatic test_side_effects();
        send_beat(beat(CMD_SELECT, REG_SLOT_FIRST, 8'h00, 3'd0, 8'h00));
        send_beat(beat(CMD_WRITE_SEL, 8'h00, 8'hFF, 3'd0, 8'h00));
        send_beat(beat(CMD_WRITE_DIR, REG_SLOT_LAST, 8'h00, 3'd0, 8'h00));
        send_beat(beat(CMD_WRITE_DIR, REG_SPEED, 8'h03, 3'd0, 8'h00));
        // Same low bits as stored: the byte changes but the speed does not.
        send_beat(beat(CMD_WRITE_DIR, REG_SPEED, 8'hFF, 3'd0, 8'h00));
        send_beat(beat(CMD_WRITE_DIR, REG_SPEED, 8'h00, 3'd0, 8'h00));
        send_beat(beat(CMD_WRITE_DIR, REG_PAL_SELECT, 8'h70, 3'd0, 8'h00));
        send_beat(beat(CMD_WRITE_DIR, REG_PAL_INDEX, 8'hFF, 3'd0, 8'h00));
        // Both palette data writes at the last index make the pointer wrap.
        send_beat(beat(CMD_WRITE_DIR, REG_PAL_DATA8, 8'hFF, 3'd0, 8'h00));
        send_beat(beat(CMD_WRITE_DIR, REG_PAL_INDEX, 8'hFF, 3'd0, 8'h00));
        send_beat(beat(CMD_WRITE_DIR, REG_PAL_DATA9, 8'h81, 3'd0, 8'h00));
        send_beat(beat(CMD_LOOKUP, 8'h00, 8'h00, 3'd7, 8'hFF));
        send_beat(beat(CMD_WRITE_DIR, REG_PAL_DATA9, 8'h00, 3'd0, 8'h00));
        send_beat(beat(CMD_SELECT, REG_PAL_DATA8, 8'h00, 3'd0, 8'h00));
        send_beat(beat(CMD_WRITE_SEL, 8'hFF, 8'h00, 3'd0, 8'h00));
        send_beat(beat(CMD_READ, REG_PAL_DATA8, 8'h00, 3'd0, 8'h00));
        send_beat(beat(CMD_LOOKUP, 8'h00, 8'h00, 3'd7, 8'h01));
        send_beat(beat(CMD_WRITE_DIR, 8'hFF, 8'hA5, 3'd0, 8'h00));
        send_beat(beat(CMD_READ, 8'hFF, 8'h00, 3'd0, 8'h00));
        send_beat(beat(CMD_UNUSED_LO, 8'hFF, 8'hFF, 3'd7, 8'hFF));
        send_beat(beat(CMD_UNUSED_HI, REG_SPEED, 8'hFF, 3'd7, 8'hFF));
    endtask

    task automatic test_random_traffic(input int count, input int src_pct,
                                       input int rcv_pct);
        int target;
        target       = beats_sent + count;
        src_idle_pct = src_pct;
        rcv_idle_pct = rcv_pct;
        while (beats_sent < target)
        begin
            if ($urandom_range(0, 99) < 25)
                palette_burst();
            else
                send_beat(random_beat());
        end
    endtask

    // The output is held off long enough for the block to stall its input.
    task automatic test_output_hold();
        src_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_len     = 60;
        repeat (30)
        begin
            send_beat(random_beat());
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_count < hold_len)
        begin
            rsp_stall <= 1'b1;
            hold_count = hold_count + 1;
        end
        else
        begin
            rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        rsp_beat_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (rsp_due.size() == 0)
            begin
                $error("result beat arrived with none outstanding");
                fail_count++;
            end
            else
            begin
                want = rsp_due.pop_front();
                check_field("read_data", 32'(want.read_data), 32'(rsp.read_data));
                check_field("palette_entry", 32'(want.palette_entry),
                            32'(rsp.palette_entry));
                check_field("slot_write", 32'(want.slot_write), 32'(rsp.slot_write));
                check_field("slot_number", 32'(want.slot_number), 32'(rsp.slot_number));
                check_field("slot_page", 32'(want.slot_page), 32'(rsp.slot_page));
                check_field("speed_change", 32'(want.speed_change),
                            32'(rsp.speed_change));
                check_field("speed_mult", 32'(want.speed_mult), 32'(rsp.speed_mult));
            end
        end
    end

    initial
    begin
        #(12 * 400000);
        $display("** indexed_register_file_palette_top: FAILED **");
        $finish;
    end

    initial
    begin
        int guard;
        clear_state();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_values();
        test_side_effects();
        test_random_traffic(430, 30, 49);
        test_random_traffic(430, 49, 30);
        test_output_hold();
        test_random_traffic(400, 0, 0);
        req_valid <= 1'b0;
        guard = 0;
        while (rsp_due.size() != 0 && guard < 50000)
        begin
            @(posedge clk);
            guard++;
        end
        if (rsp_due.size() != 0)
        begin
            $error("%0d result beats never arrived", rsp_due.size());
            fail_count++;
        end
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("** indexed_register_file_palette_top: PASSED **");
        else
            $display("** indexed_register_file_palette_top: FAILED **");
        $finish;
    end

endmodule
